FILE: src/rcfp_pkg.sv
// shared constants and widths for the rc serial frame channel parser
package rcfp_pkg;

  localparam int FRAME_BYTES  = 32;
  localparam int NUM_CHANNELS = 14;
  localparam int ADDR_W       = $clog2(FRAME_BYTES);
  localparam int CH_W         = 4;

  localparam logic [7:0]  SYNC_FIRST  = 8'h20;
  localparam logic [7:0]  SYNC_SECOND = 8'h40;
  localparam logic [15:0] SUM_START   = 16'hFFFF;
  localparam logic [15:0] CLAMP_LOW   = 16'd1000;
  localparam logic [15:0] CLAMP_HIGH  = 16'd2000;

  localparam int SPAN_W      = 10;
  localparam int RECIP_W     = 25;
  localparam int PROD_W      = SPAN_W + RECIP_W;
  localparam int SCALE_SHIFT = 18;
  // ceil(65.535 * 2^18), floor of the product is exact for spans 0..1000
  localparam logic [RECIP_W-1:0] SCALE_RECIP = 25'd17179608;

  localparam logic [1:0] KIND_CHAN = 2'd0;
  localparam logic [1:0] KIND_SYNC = 2'd1;
  localparam logic [1:0] KIND_CSUM = 2'd2;

endpackage

FILE: src/rcfp_frame_mem.sv
// frame byte store with one write port and one registered read port
module rcfp_frame_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [rcfp_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [rcfp_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                 rdata
);
  import rcfp_pkg::*;

  logic [7:0] mem_r [FRAME_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/rcfp_scale_div.sv
// scaled value unit: span * 65535 / 1000 by reciprocal multiply, result registered in the cycle after start
module rcfp_scale_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rcfp_pkg::SPAN_W-1:0] span,
  output logic                       done,
  output logic [15:0]                quotient
);
  import rcfp_pkg::*;

  logic              done_r, done_nxt;
  logic [15:0]       q_r, q_nxt;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(span) * PROD_W'(SCALE_RECIP);

  always_comb begin
    done_nxt = start;
    q_nxt    = start ? prod[SCALE_SHIFT +: 16] : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: src/rc_serial_frame_channel_parser.sv
// top level: sync hunt, frame gather, checksum and channel result sequencer
//
// Takes one serial byte per accepted word and hunts for the sync pair 0x20 0x40,
// then gathers the rest of a 32-byte frame into an internal store while keeping
// a running checksum. Sync, payload and checksum bytes are accepted back to
// back while in_stall is low; a bad sync byte or a checksum mismatch yields
// a single error word and holds in_stall high until it is written to the
// output. The final byte of a good frame starts the channel sequencer, which
// emits 14 channel words: per channel two store reads, a clamp, a reciprocal
// multiply for the scaled value and the output write, with in_stall high
// throughout. A stalled output holds the sequencer in its emit state. The
// output register lets a new byte be taken while the previous result still
// waits.
module rc_serial_frame_channel_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_channel_index,
  output logic [15:0] out_raw_value,
  output logic [15:0] out_scaled_value,
  output logic        out_last
);
  import rcfp_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EMIT_ER = 3'd1;
  localparam logic [2:0] S_RD_LO   = 3'd2;
  localparam logic [2:0] S_RD_HI   = 3'd3;
  localparam logic [2:0] S_CLAMP   = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_EMIT_CH = 3'd6;

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_SYNC2 = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [ADDR_W-1:0] count_r, count_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [7:0]        csum_lo_r, csum_lo_nxt;
  logic [1:0]        err_kind_r, err_kind_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [15:0]       raw_r, raw_nxt;
  logic [15:0]       scaled_r, scaled_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [CH_W-1:0]   out_ch_r, out_ch_nxt;
  logic [15:0]       out_raw_r, out_raw_nxt;
  logic [15:0]       out_scaled_r, out_scaled_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              out_free;
  logic [15:0]       sub_a;
  logic [15:0]       sub_diff;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  logic [15:0]       raw_full;
  logic [SPAN_W-1:0] span;
  logic              div_start;
  logic              div_done;
  logic [15:0]       div_q;
  logic              ch_last;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign ch_last  = (ch_r == CH_W'(NUM_CHANNELS - 1));

  // shared checksum subtractor
  assign sub_a    = (phase_r == PH_SYNC2 || phase_r == PH_BODY) ? sum_r : SUM_START;
  assign sub_diff = sub_a - {8'b0, in_rx_byte};

  assign raw_full = {mem_rdata, raw_r[7:0]};

  always_comb begin
    if (raw_full <= CLAMP_LOW) begin
      span = '0;
    end else if (raw_full >= CLAMP_HIGH) begin
      span = SPAN_W'(CLAMP_HIGH - CLAMP_LOW);
    end else begin
      span = SPAN_W'(raw_full - CLAMP_LOW);
    end
  end

  assign div_start = (state_r == S_CLAMP);
  assign mem_raddr = (state_r == S_RD_LO) ? ADDR_W'({ch_r, 1'b0} + 5'd2)
                                          : ADDR_W'({ch_r, 1'b0} + 5'd3);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    csum_lo_nxt    = csum_lo_r;
    err_kind_nxt   = err_kind_r;
    ch_nxt         = ch_r;
    raw_nxt        = raw_r;
    scaled_nxt     = scaled_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_ch_nxt     = out_ch_r;
    out_raw_nxt    = out_raw_r;
    out_scaled_nxt = out_scaled_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (phase_r)
            PH_SYNC2: begin
              if (in_rx_byte != SYNC_SECOND) begin
                phase_nxt    = PH_HUNT;
                err_kind_nxt = KIND_SYNC;
                state_nxt    = S_EMIT_ER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(1);
                sum_nxt   = sub_diff;
                count_nxt = ADDR_W'(2);
                phase_nxt = PH_BODY;
              end
            end
            PH_BODY: begin
              mem_we = 1'b1;
              if (count_r < ADDR_W'(FRAME_BYTES - 2)) begin
                sum_nxt = sub_diff;
              end
              if (count_r == ADDR_W'(FRAME_BYTES - 2)) begin
                csum_lo_nxt = in_rx_byte;
              end
              if (count_r != ADDR_W'(FRAME_BYTES - 1)) begin
                count_nxt = count_r + 1'b1;
              end else begin
                phase_nxt = PH_HUNT;
                count_nxt = '0;
                if ({in_rx_byte, csum_lo_r} != sum_r) begin
                  err_kind_nxt = KIND_CSUM;
                  state_nxt    = S_EMIT_ER;
                end else begin
                  ch_nxt    = '0;
                  state_nxt = S_RD_LO;
                end
              end
            end
            default: begin
              phase_nxt = PH_HUNT;
              if (in_rx_byte != SYNC_FIRST) begin
                err_kind_nxt = KIND_SYNC;
                state_nxt    = S_EMIT_ER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                sum_nxt   = sub_diff;
                count_nxt = ADDR_W'(1);
                phase_nxt = PH_SYNC2;
              end
            end
          endcase
        end
      end
      S_EMIT_ER: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = err_kind_r;
          out_ch_nxt     = '0;
          out_raw_nxt    = '0;
          out_scaled_nxt = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RD_LO: begin
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        raw_nxt   = {8'b0, mem_rdata};
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        raw_nxt   = raw_full;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          scaled_nxt = div_q;
          state_nxt  = S_EMIT_CH;
        end
      end
      S_EMIT_CH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_CHAN;
          out_ch_nxt     = ch_r;
          out_raw_nxt    = raw_r;
          out_scaled_nxt = scaled_r;
          out_last_nxt   = ch_last;
          if (ch_last) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_RD_LO;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HUNT;
      count_r     <= '0;
      sum_r       <= SUM_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    csum_lo_r    <= csum_lo_nxt;
    err_kind_r   <= err_kind_nxt;
    ch_r         <= ch_nxt;
    raw_r        <= raw_nxt;
    scaled_r     <= scaled_nxt;
    out_kind_r   <= out_kind_nxt;
    out_ch_r     <= out_ch_nxt;
    out_raw_r    <= out_raw_nxt;
    out_scaled_r <= out_scaled_nxt;
    out_last_r   <= out_last_nxt;
  end

  rcfp_frame_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_rx_byte),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rcfp_scale_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .span     (span),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_channel_index = out_ch_r;
  assign out_raw_value     = out_raw_r;
  assign out_scaled_value  = out_scaled_r;
  assign out_last          = out_last_r;

endmodule

FILE: tb/rc_serial_frame_channel_parser_tb.sv
// testbench for rc_serial_frame_channel_parser: byte stream stimulus, frame predictor, result check
`timescale 1ns / 1ps

module rc_serial_frame_channel_parser_tb;
  import rcfp_pkg::*;

  localparam int RANDOM_BYTES = 265;
  localparam int SCALE_FULL   = 65535;
  localparam int TAIL_CYCLES  = 600;
  localparam int HOLD_CYCLES  = 2500;
  localparam int HOLD_AFTER   = 150;

  typedef enum logic [1:0] {HUNT_FIRST, WANT_SECOND, GATHER} phase_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  chan;
    logic [15:0] raw;
    logic [15:0] scaled;
    logic        last;
  } chan_result_t;

  typedef struct {
    logic [7:0] b;
    bit         drain;
  } serial_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_channel_index;
  logic [15:0] out_raw_value;
  logic [15:0] out_scaled_value;
  logic        out_last;

  // frame predictor state
  phase_t      phase;
  logic [4:0]  byte_idx;
  logic [15:0] csum_left;
  logic [7:0]  frame_img [FRAME_BYTES];

  chan_result_t results_due [$];
  serial_word_t bytes_to_send [$];
  bit           drain_next = 1'b0;
  int           rx_accepted = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  bit           send_calm = 1'b0;
  bit           recv_calm = 1'b0;
  logic         hold_off = 1'b0;

  rc_serial_frame_channel_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_channel_index (out_channel_index),
    .out_raw_value     (out_raw_value),
    .out_scaled_value  (out_scaled_value),
    .out_last          (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] scale_stick(input logic [15:0] raw);
    int unsigned c;
    c = raw;
    if (c < CLAMP_LOW) c = CLAMP_LOW;
    if (c > CLAMP_HIGH) c = CLAMP_HIGH;
    return 16'((c - CLAMP_LOW) * SCALE_FULL / (CLAMP_HIGH - CLAMP_LOW));
  endfunction

  function automatic void push_error(input logic [1:0] kind);
    chan_result_t r;
    r.kind = kind;
    r.chan = '0;
    r.raw = '0;
    r.scaled = '0;
    r.last = 1'b1;
    results_due.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [15:0] sent;
    chan_result_t r;
    case (phase)
      WANT_SECOND: begin
        if (b != SYNC_SECOND) begin
          phase = HUNT_FIRST;
          push_error(KIND_SYNC);
        end else begin
          frame_img[1] = b;
          csum_left = csum_left - b;
          byte_idx = 5'd2;
          phase = GATHER;
        end
      end
      GATHER: begin
        frame_img[byte_idx] = b;
        if (byte_idx < FRAME_BYTES - 2) csum_left = csum_left - b;
        if (byte_idx < FRAME_BYTES - 1) begin
          byte_idx = byte_idx + 5'd1;
        end else begin
          phase = HUNT_FIRST;
          byte_idx = '0;
          sent = {frame_img[FRAME_BYTES - 1], frame_img[FRAME_BYTES - 2]};
          if (sent != csum_left) begin
            push_error(KIND_CSUM);
          end else begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              r.kind = KIND_CHAN;
              r.chan = 4'(i);
              r.raw = {frame_img[3 + 2 * i], frame_img[2 + 2 * i]};
              r.scaled = scale_stick(r.raw);
              r.last = (i == NUM_CHANNELS - 1);
              results_due.push_back(r);
            end
          end
        end
      end
      default: begin
        if (b != SYNC_FIRST) begin
          push_error(KIND_SYNC);
        end else begin
          frame_img[0] = b;
          csum_left = SUM_START - b;
          byte_idx = 5'd1;
          phase = WANT_SECOND;
        end
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic int idle_cycles(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(40, 150);
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    serial_word_t w;
    w.b = b;
    w.drain = drain_next;
    drain_next = 1'b0;
    bytes_to_send.push_back(w);
  endfunction

  function automatic void queue_frame(input logic [15:0] vals [NUM_CHANNELS],
                                      input bit bad_sum);
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] left;
    logic [15:0] flip;
    fb[0] = SYNC_FIRST;
    fb[1] = SYNC_SECOND;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      fb[2 + 2 * i] = vals[i][7:0];
      fb[3 + 2 * i] = vals[i][15:8];
    end
    left = SUM_START;
    for (int i = 0; i < FRAME_BYTES - 2; i++) left = left - fb[i];
    if (bad_sum) begin
      flip = 16'($urandom_range(1, 65535));
      left = left ^ flip;
    end
    fb[FRAME_BYTES - 2] = left[7:0];
    fb[FRAME_BYTES - 1] = left[15:8];
    for (int i = 0; i < FRAME_BYTES; i++) push_byte(fb[i]);
  endfunction

  function automatic logic [15:0] pick_raw();
    logic [15:0] edges [10];
    int unsigned r;
    edges = '{16'd0, 16'd999, 16'd1000, 16'd1001, 16'd1999, 16'd2000, 16'd2001,
              16'hFFFF, 16'h8000, 16'h00FF};
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(1000, 2000));
    if (r < 65) return 16'($urandom_range(0, 999));
    if (r < 80) return 16'($urandom_range(2001, 65535));
    return edges[$urandom_range(0, 9)];
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_rx_byte(in_rx_byte);
        rx_accepted++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (bytes_to_send.size() != 0 &&
                   !(bytes_to_send[0].drain && results_due.size() != 0)) begin
        in_valid <= 1'b1;
        in_rx_byte <= bytes_to_send[0].b;
        void'(bytes_to_send.pop_front());
        if ($urandom_range(0, 40) == 0) send_calm = !send_calm;
        send_gap = idle_cycles(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    chan_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          note_mismatch("result with none due, kind", out_kind, 0);
        end else begin
          want = results_due.pop_front();
          if (out_kind !== want.kind) note_mismatch("kind", out_kind, want.kind);
          if (out_channel_index !== want.chan)
            note_mismatch("channel_index", out_channel_index, want.chan);
          if (out_raw_value !== want.raw)
            note_mismatch("raw_value", out_raw_value, want.raw);
          if (out_scaled_value !== want.scaled)
            note_mismatch("scaled_value", out_scaled_value, want.scaled);
          if (out_last !== want.last) note_mismatch("last", out_last, want.last);
        end
        results_seen++;
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 40) == 0) recv_calm = !recv_calm;
        if ($urandom_range(0, 2) == 0) recv_gap = idle_cycles(recv_calm);
      end
    end
  end

  // long receiver hold-off so the sequencer backs up into the input
  initial begin
    while (rx_accepted < HOLD_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [15:0] vals [NUM_CHANNELS];
    logic [7:0]  b;
    int          directed_n;
    int unsigned pick;

    phase = HUNT_FIRST;
    byte_idx = '0;
    csum_left = SUM_START;
    for (int i = 0; i < FRAME_BYTES; i++) frame_img[i] = '0;

    // bad first sync bytes, bad second sync byte, repeated first sync byte
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SYNC_FIRST);
    push_byte(8'h41);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    // good frame across the clamp edges, then the same frame with a bad checksum
    vals = '{16'd0, 16'd999, 16'd1000, 16'd1001, 16'd1500, 16'd1999, 16'd2000,
             16'd2001, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h5A5A, 16'd1234, 16'h8000};
    queue_frame(vals, 1'b0);
    queue_frame(vals, 1'b1);
    directed_n = bytes_to_send.size();

    drain_next = 1'b1;
    while (bytes_to_send.size() < directed_n + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        for (int i = 0; i < NUM_CHANNELS; i++) vals[i] = pick_raw();
        if ($urandom_range(0, 9) == 0) drain_next = 1'b1;
        queue_frame(vals, 1'b0);
      end else if (pick < 72) begin
        for (int i = 0; i < NUM_CHANNELS; i++) vals[i] = pick_raw();
        queue_frame(vals, 1'b1);
      end else if (pick < 80) begin
        b = 8'($urandom_range(0, 255));
        if (b == SYNC_SECOND) b = b ^ 8'h01;
        push_byte(SYNC_FIRST);
        push_byte(b);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        // truncated frame: following bytes get swallowed into it
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        repeat ($urandom_range(1, 29)) push_byte(8'($urandom_range(0, 255)));
      end
    end
    directed_n = bytes_to_send.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_accepted < directed_n) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: rc_serial_frame_channel_parser.f
src/rcfp_pkg.sv
src/rcfp_frame_mem.sv
src/rcfp_scale_div.sv
src/rc_serial_frame_channel_parser.sv
tb/rc_serial_frame_channel_parser_tb.sv
